### hdl/bf_pkg.sv
// Package for the 5x5 box filter: configuration register constants and the
// flag struct passed from the position tracker to the datapath.
// No dependencies.
`default_nettype none

package bf_pkg;

    // image_size register
    localparam int unsigned            CFG_BITS  = 13;
    localparam logic [CFG_BITS-1:0]    CFG_RESET = 13'd4096;

    // per-item control flags from the position tracker
    typedef struct packed {
        logic emit;   // window complete, a result follows
        logic last;   // last pixel of the image, marks the last result
    } bf_flags_t;

endpackage

`default_nettype wire

### hdl/bf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone, no package dependencies.
`default_nettype none

module bf_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/bf_cell.sv
// One column cell of the window chain: holds the sum of one window column,
// hands it to its left neighbour on a shift and adds it to the running sum.
// No package dependencies.
`default_nettype none

module bf_cell #(
    parameter int unsigned COL_W = 19,
    parameter int unsigned SUM_W = 21
) (
    input  wire logic             aclk,
    input  wire logic             shift_en,
    input  wire logic [COL_W-1:0] col_in,
    output logic      [COL_W-1:0] col_out,
    input  wire logic [SUM_W-1:0] part_in,
    output logic      [SUM_W-1:0] part_out
);

    logic [COL_W-1:0] col_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out  = col_reg;
    assign part_out = part_in + SUM_W'(col_reg);

endmodule

`default_nettype wire

### hdl/bf_pos.sv
// Raster position tracker: frame start, wrap on a shrunk size, window-ready
// and end-of-frame flags, centre coordinates. Uses bf_pkg.
`default_nettype none

module bf_pos #(
    parameter int unsigned MAX_DIM    = 4096,
    parameter int unsigned HALF_WIDTH = 2
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         advance,
    input  wire logic                         frame_start,
    input  wire logic [bf_pkg::CFG_BITS-1:0]  image_size,
    output logic      [$clog2(MAX_DIM)-1:0]   cur_col,
    output logic      [$clog2(2*HALF_WIDTH)-1:0] cur_slot,
    output logic      [$clog2(MAX_DIM)-1:0]   ctr_row,
    output logic      [$clog2(MAX_DIM)-1:0]   ctr_col,
    output bf_pkg::bf_flags_t                 flags
);

    localparam int unsigned PW    = $clog2(MAX_DIM);
    localparam int unsigned NW    = $clog2(MAX_DIM + 1);
    localparam int unsigned CW    = (NW > bf_pkg::CFG_BITS) ? NW : bf_pkg::CFG_BITS;
    localparam int unsigned WIN   = 2 * HALF_WIDTH + 1;
    localparam int unsigned LINES = 2 * HALF_WIDTH;
    localparam int unsigned SLW   = $clog2(LINES);

    logic [PW-1:0] row_reg, row_next;
    logic [PW-1:0] col_reg, col_next;
    // row index modulo LINES, picks the line store lane
    logic [SLW-1:0] slot_reg, slot_next;

    logic [CW-1:0]  size_ext, size_clamp;
    logic [NW-1:0]  n;
    logic [NW-1:0]  r0, c0, r1, r, c;
    logic [SLW-1:0] s0, s1, s;

    always_comb begin
        size_ext = CW'(image_size);
        if (size_ext < CW'(WIN)) begin
            size_clamp = CW'(WIN);
        end else if (size_ext > CW'(MAX_DIM)) begin
            size_clamp = CW'(MAX_DIM);
        end else begin
            size_clamp = size_ext;
        end
        n = size_clamp[NW-1:0];

        r0 = frame_start ? '0 : NW'(row_reg);
        c0 = frame_start ? '0 : NW'(col_reg);
        s0 = frame_start ? '0 : slot_reg;

        // column past a shrunk size wraps before use
        if (c0 >= n) begin
            c  = '0;
            r1 = r0 + NW'(1);
            s1 = (s0 == SLW'(LINES - 1)) ? '0 : s0 + SLW'(1);
        end else begin
            c  = c0;
            r1 = r0;
            s1 = s0;
        end
        r = (r1 >= n) ? '0 : r1;
        s = (r1 >= n) ? '0 : s1;

        flags.emit = (r >= NW'(LINES)) && (c >= NW'(LINES));
        flags.last = (r == n - NW'(1)) && (c == n - NW'(1));

        if (c + NW'(1) >= n) begin
            col_next = '0;
            if (r + NW'(1) >= n) begin
                row_next  = '0;
                slot_next = '0;
            end else begin
                row_next  = PW'(r + NW'(1));
                slot_next = (s == SLW'(LINES - 1)) ? '0 : s + SLW'(1);
            end
        end else begin
            col_next  = PW'(c + NW'(1));
            row_next  = PW'(r);
            slot_next = s;
        end

        cur_col  = PW'(c);
        cur_slot = s;
        ctr_row  = PW'(r - NW'(HALF_WIDTH));
        ctr_col  = PW'(c - NW'(HALF_WIDTH));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= '0;
        end else if (advance) begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

### hdl/box_filter_5x5_average_top.sv
// 5x5 box filter top level: position tracker, packed line store, column
// cell chain, reciprocal divide and output skid. Uses bf_pkg, bf_ram,
// bf_cell and bf_pos.
//
// Usage:
//   s_ channel: one sample per item in raster order, tuser marks the first
//   sample of an image. m_ channel: one result per interior pixel, with the
//   rounded window mean, centre row and column; tlast marks the last
//   interior result. Border pixels give no result.
//   cfg channel: writes image_size (always ready); write only while idle.
//   Throughput: one item per cycle while the skid register is empty. The line
//   store is a single RAM holding the four previous rows packed per column,
//   read and rewritten once per item, so it never limits the rate.
//   Path from the accepting edge to m_tvalid: line store read on the
//   accepting edge, then column chain shift, window sum, multiply and
//   output register.
//   Reset: position returns to row 0, column 0, image_size to 4096, all
//   in-flight items are dropped. The line store needs no clearing pass.
//   Stall: a result waiting on m_tready parks in the output register and
//   the pipeline keeps moving until a second result lands in the skid
//   register; s_tready then drops until the receiver takes one.
`default_nettype none

module box_filter_5x5_average_top #(
    parameter int unsigned MAX_DIM     = 4096,
    parameter int unsigned HALF_WIDTH  = 2,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // tdata: sample
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    // tuser: frame_start
    input  wire logic [0:0]                            s_tuser,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // tdata: mean, row, col
    output logic [((SAMPLE_BITS+2*$clog2(MAX_DIM)+7)/8)*8-1:0] m_tdata,
    output logic                                       m_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    input  wire logic [bf_pkg::CFG_BITS-1:0]           cfg_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready
);

    localparam int unsigned SB     = SAMPLE_BITS;
    localparam int unsigned PW     = $clog2(MAX_DIM);
    localparam int unsigned WIN    = 2 * HALF_WIDTH + 1;
    localparam int unsigned LINES  = 2 * HALF_WIDTH;
    localparam int unsigned SLW    = $clog2(LINES);
    localparam int unsigned AREA   = WIN * WIN;
    localparam int unsigned COL_W  = SB + $clog2(WIN);
    localparam int unsigned SUM_W  = SB + $clog2(AREA);
    localparam int unsigned SHIFT  = SUM_W + $clog2(AREA);
    localparam int unsigned RW     = SUM_W + 1;
    localparam int unsigned OUT_W  = ((SB + 2 * PW + 7) / 8) * 8;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + longint'(AREA) - 64'd1) / longint'(AREA);
    localparam logic [RW-1:0] RECIP = RECIP_L[RW-1:0];

    // ---------------- configuration ----------------
    logic [bf_pkg::CFG_BITS-1:0] image_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg <= bf_pkg::CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            image_size_reg <= cfg_data;
        end
    end

    // ---------------- flow control ----------------
    logic skid_valid_reg;
    logic adv;
    logic accept;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    // ---------------- position ----------------
    logic [PW-1:0]     cur_col, ctr_row, ctr_col;
    logic [SLW-1:0]    cur_slot;
    bf_pkg::bf_flags_t pos_flags;

    bf_pos #(
        .MAX_DIM    (MAX_DIM),
        .HALF_WIDTH (HALF_WIDTH)
    ) u_pos (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (accept),
        .frame_start (s_tuser[0]),
        .image_size  (image_size_reg),
        .cur_col     (cur_col),
        .cur_slot    (cur_slot),
        .ctr_row     (ctr_row),
        .ctr_col     (ctr_col),
        .flags       (pos_flags)
    );

    // ---------------- stage 1: line store read ----------------
    logic              p1_valid_reg;
    logic [SB-1:0]     p1_sample_reg;
    logic [PW-1:0]     p1_addr_reg;
    logic [SLW-1:0]    p1_slot_reg;
    logic [PW-1:0]     p1_row_reg, p1_col_reg;
    bf_pkg::bf_flags_t p1_flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_sample_reg <= s_tdata[SB-1:0];
            p1_addr_reg   <= cur_col;
            p1_slot_reg   <= cur_slot;
            p1_row_reg    <= ctr_row;
            p1_col_reg    <= ctr_col;
            p1_flags_reg  <= pos_flags;
        end
    end

    // lane k holds the latest row whose index is k modulo LINES at this column
    logic [LINES*SB-1:0] ls_rd, ls_wr;
    logic [COL_W-1:0]    col_sum;
    logic                p1_fire;

    assign p1_fire = adv && p1_valid_reg;

    always_comb begin
        col_sum = COL_W'(p1_sample_reg);
        for (int i = 0; i < int'(LINES); i++) begin
            col_sum = col_sum + COL_W'(ls_rd[i*SB +: SB]);
        end
        ls_wr = ls_rd;
        ls_wr[int'(p1_slot_reg)*SB +: SB] = p1_sample_reg;
    end

    bf_ram #(
        .WIDTH (LINES * SB),
        .DEPTH (MAX_DIM)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (p1_fire),
        .wr_addr (p1_addr_reg),
        .wr_data (ls_wr),
        .rd_en   (adv),
        .rd_addr (cur_col),
        .rd_data (ls_rd)
    );

    // ---------------- column cell chain ----------------
    logic [COL_W-1:0] col_link  [WIN];
    logic [SUM_W-1:0] part_link [WIN+1];

    assign part_link[0] = SUM_W'(AREA / 2);

    for (genvar g = 0; g < int'(WIN); g++) begin : g_cell
        logic [COL_W-1:0] cell_in;
        if (g == int'(WIN) - 1) begin : g_head
            assign cell_in = col_sum;
        end else begin : g_body
            assign cell_in = col_link[g+1];
        end

        bf_cell #(
            .COL_W (COL_W),
            .SUM_W (SUM_W)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (p1_fire),
            .col_in   (cell_in),
            .col_out  (col_link[g]),
            .part_in  (part_link[g]),
            .part_out (part_link[g+1])
        );
    end

    // ---------------- stages 2..4: sum, multiply, scale ----------------
    logic              p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic [PW-1:0]     p2_row_reg, p3_row_reg, p4_row_reg;
    logic [PW-1:0]     p2_col_reg, p3_col_reg, p4_col_reg;
    logic              p2_last_reg, p3_last_reg, p4_last_reg;
    logic [SUM_W-1:0]  p3_sum_reg;
    logic [SUM_W+RW-1:0] p4_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= p1_valid_reg && p1_flags_reg.emit;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_row_reg  <= p1_row_reg;
            p2_col_reg  <= p1_col_reg;
            p2_last_reg <= p1_flags_reg.last;
            // cells now hold the window of the item in stage 2
            p3_sum_reg  <= part_link[WIN];
            p3_row_reg  <= p2_row_reg;
            p3_col_reg  <= p2_col_reg;
            p3_last_reg <= p2_last_reg;
            p4_prod_reg <= (SUM_W+RW)'(p3_sum_reg) * (SUM_W+RW)'(RECIP);
            p4_row_reg  <= p3_row_reg;
            p4_col_reg  <= p3_col_reg;
            p4_last_reg <= p3_last_reg;
        end
    end

    logic [SB-1:0] p4_mean;
    assign p4_mean = p4_prod_reg[SHIFT +: SB];

    // ---------------- output register and skid ----------------
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg, skid_data_reg;
    logic              out_last_reg, skid_last_reg;
    logic [OUT_W-1:0]  new_data;
    logic              new_res;

    assign new_data = OUT_W'({p4_col_reg, p4_row_reg, p4_mean});
    assign new_res  = adv && p4_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg   <= skid_data_reg;
                out_last_reg   <= skid_last_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (new_res) begin
            if (!out_valid_reg || m_tready) begin
                out_data_reg  <= new_data;
                out_last_reg  <= p4_last_reg;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= new_data;
                skid_last_reg  <= p4_last_reg;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

### tb/sv/box_filter_5x5_average_checker.sv
// Checker for the 5x5 box filter: follows the cfg, s_ and m_ channels, keeps
// its own line store and window, and compares every result with the predicted one.
// Depends on bf_pkg for the width and reset value of the image_size register.
module box_filter_5x5_average_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [15:0]                 s_tdata,
    input  logic [0:0]                  s_tuser,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [39:0]                 m_tdata,
    input  logic                        m_tlast,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [bf_pkg::CFG_BITS-1:0] cfg_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    output int                          mismatches,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_DIM  = 4096;
    localparam int unsigned MIN_DIM  = 5;
    localparam int unsigned SPAN     = 5;
    localparam int unsigned LINES    = 4;
    localparam int unsigned HALF     = 2;
    localparam int unsigned AREA     = 25;
    localparam int unsigned MAX_SHOWN = 50;

    typedef struct packed {
        logic [15:0] mean;
        logic [11:0] row;
        logic [11:0] col;
        logic        frame_end;
    } box_mean_t;

    logic [15:0] line_mem [0:LINES-1][0:MAX_DIM-1];
    logic [15:0] win [0:SPAN-1][0:SPAN-1];
    int unsigned pos_row, pos_col;
    logic [bf_pkg::CFG_BITS-1:0] size_reg;
    box_mean_t   mean_q [$];

    function automatic int unsigned size_in_force(logic [bf_pkg::CFG_BITS-1:0] v);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%0t ns mismatch: %s", $time, what);
    endtask

    // one item: shift the window, update the line store, queue the mean if interior
    task automatic predict_mean(input logic [15:0] smp, input logic first);
        int unsigned n, r, c;
        logic [20:0] total;
        box_mean_t   res;
        n = size_in_force(size_reg);
        if (first) begin
            pos_row = 0;
            pos_col = 0;
        end
        // size may have shrunk since the last item
        if (pos_col >= n) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= n)
            pos_row = 0;
        r = pos_row;
        c = pos_col;
        for (int i = 0; i < SPAN; i++)
            for (int j = 0; j < SPAN - 1; j++)
                win[i][j] = win[i][j+1];
        for (int i = 0; i < LINES; i++)
            win[i][SPAN-1] = line_mem[(r + i) % LINES][c];
        win[SPAN-1][SPAN-1] = smp;
        line_mem[r % LINES][c] = smp;
        if (r >= LINES && c >= LINES) begin
            total = '0;
            for (int i = 0; i < SPAN; i++)
                for (int j = 0; j < SPAN; j++)
                    total += 21'(win[i][j]);
            res.mean      = 16'((total + AREA / 2) / AREA);
            res.row       = 12'(r - HALF);
            res.col       = 12'(c - HALF);
            res.frame_end = (r == n - 1) && (c == n - 1);
            mean_q.push_back(res);
        end
        if (c + 1 >= n) begin
            pos_col = 0;
            pos_row = (r + 1 >= n) ? 0 : r + 1;
        end else begin
            pos_col = c + 1;
        end
    endtask

    always @(posedge aclk) begin
        box_mean_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < LINES; i++)
                for (int j = 0; j < MAX_DIM; j++)
                    line_mem[i][j] = '0;
            for (int i = 0; i < SPAN; i++)
                for (int j = 0; j < SPAN; j++)
                    win[i][j] = '0;
            pos_row    = 0;
            pos_col    = 0;
            size_reg   = bf_pkg::CFG_RESET;
            mismatches = 0;
            mean_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                size_reg = cfg_data;
            if (s_tvalid && s_tready)
                predict_mean(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready) begin
                got = '{mean: m_tdata[15:0], row: m_tdata[27:16], col: m_tdata[39:28],
                        frame_end: m_tlast};
                if (mean_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item mean=%h row=%0d col=%0d last=%b",
                                              got.mean, got.row, got.col, got.frame_end));
                end else begin
                    want = mean_q.pop_front();
                    if (got.mean !== want.mean || got.row !== want.row ||
                        got.col !== want.col || got.frame_end !== want.frame_end)
                        report_mismatch($sformatf(
                            "got mean=%h row=%0d col=%0d last=%b, want %h %0d %0d %b",
                            got.mean, got.row, got.col, got.frame_end,
                            want.mean, want.row, want.col, want.frame_end));
                end
            end
        end
        pending = mean_q.size();
    end

endmodule

### tb/sv/box_filter_5x5_average_top_test.sv
// Top of the 5x5 box filter testbench: clock, reset, image_size writes,
// sample stimulus in bursts and a stalling receiver; the checker judges results.
// Depends on bf_pkg, box_filter_5x5_average_top and box_filter_5x5_average_checker.
module box_filter_5x5_average_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MIN_SIZE    = 5;
    localparam int unsigned MAX_SIZE    = 4096;
    localparam int unsigned ITEM_GOAL   = 1850;
    localparam int unsigned BIG_RUN     = 300;
    localparam int unsigned SETTLE      = 12;

    typedef enum int { BIAS_MIX, BIAS_HIGH, BIAS_LOW } sample_bias_t;

    logic                        aclk;
    logic                        aresetn   = 1'b0;
    logic [15:0]                 s_tdata   = '0;
    logic [0:0]                  s_tuser   = '0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [39:0]                 m_tdata;
    logic                        m_tlast;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [bf_pkg::CFG_BITS-1:0] cfg_data  = '0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;

    int          mismatches;
    int          pending;
    int          burst_left = 0;
    int          ready_run  = 0;
    int unsigned items_sent = 0;

    box_filter_5x5_average_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    box_filter_5x5_average_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_data   (cfg_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // receiver: runs of stalls, random flicker and long stretches of ready
    always @(posedge aclk) begin
        if (ready_run == 0) begin
            case ($urandom_range(0, 5))
                0: begin
                    m_tready  <= 1'b0;
                    ready_run <= $urandom_range(1, 12);
                end
                1: begin
                    m_tready  <= 1'b1;
                    ready_run <= $urandom_range(50, 200);
                end
                default: begin
                    m_tready  <= 1'($urandom_range(0, 1));
                    ready_run <= $urandom_range(1, 6);
                end
            endcase
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int unsigned clamp_size(logic [bf_pkg::CFG_BITS-1:0] v);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > MAX_SIZE)
            return MAX_SIZE;
        return v;
    endfunction

    function automatic logic [15:0] pick_sample(sample_bias_t bias);
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: begin
                case (bias)
                    BIAS_HIGH: return 16'hFFFF - 16'($urandom_range(0, 255));
                    BIAS_LOW:  return 16'($urandom_range(0, 255));
                    default:   return 16'($urandom);
                endcase
            end
        endcase
    endfunction

    // one item; bursts of random length, random gaps between them
    task automatic send_item(input logic [15:0] smp, input logic first);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? BIG_RUN : $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // hold off until every predicted item has come out, then let the pipe settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_size(input logic [bf_pkg::CFG_BITS-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [bf_pkg::CFG_BITS-1:0] specials [$];
        logic [bf_pkg::CFG_BITS-1:0] size_val;
        int unsigned cur_size, new_size, len, frames, phase;
        logic        grew, lead;
        sample_bias_t bias;

        specials = '{13'd4096, 13'd0, 13'd8191, 13'd4, 13'd12, 13'd5};
        cur_size = MAX_SIZE;
        phase    = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // smallest image at full scale: one result, largest possible window sum
        write_size(13'd5);
        cur_size = MIN_SIZE;
        for (int k = 0; k < 25; k++)
            send_item(16'hFFFF, k == 0);

        while (items_sent < ITEM_GOAL || specials.size() != 0) begin
            if (phase % 2 == 1 && specials.size() != 0)
                size_val = specials.pop_front();
            else if ($urandom_range(0, 4) == 0)
                size_val = 13'($urandom_range(11, 24));
            else
                size_val = 13'($urandom_range(5, 10));
            new_size = clamp_size(size_val);
            // growing mid-frame would read unwritten line store: restart the image
            grew = new_size > cur_size;
            write_size(size_val);
            cur_size = new_size;
            if (cur_size > 64) begin
                // huge image: only part of the first row, a later shrink cuts it short
                for (int k = 0; k < BIG_RUN; k++)
                    send_item(pick_sample(BIAS_MIX), (k == 0) && grew);
            end else begin
                frames = $urandom_range(1, 3);
                for (int f = 0; f < frames; f++) begin
                    lead = (f == 0 && grew) || ($urandom_range(0, 1) == 1);
                    len  = cur_size * cur_size;
                    if ($urandom_range(0, 9) == 0)
                        len = $urandom_range(1, len - 1);
                    bias = sample_bias_t'($urandom_range(0, 2));
                    for (int k = 0; k < len; k++)
                        send_item(pick_sample(bias),
                                  (k == 0 && lead) || ($urandom_range(0, 499) == 0));
                end
            end
            phase++;
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
hdl/bf_pkg.sv
hdl/bf_ram.sv
hdl/bf_cell.sv
hdl/bf_pos.sv
hdl/box_filter_5x5_average_top.sv
tb/sv/box_filter_5x5_average_checker.sv
tb/sv/box_filter_5x5_average_top_test.sv
